>>> hw/rtl/dlbfs_pkg.sv
// Shared types, constants and helpers for the depth-limited BFS reach counter.
// Used by the controller, the datapath and the top level; depends on nothing.
package dlbfs_pkg;

    localparam int NODE_W     = 11;
    localparam int DEPTH_W    = 6;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int MAX_NODES_DEF = 1024;

    localparam logic [NODE_W-1:0]  NODE_COUNT_RST  = 11'd1024;
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST = 6'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT = 2'd1;

    typedef enum logic {
        OP_EDGE  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [NODE_W-1:0] edge_node_a;
        logic [NODE_W-1:0] edge_node_b;
        logic [NODE_W-1:0] start_node;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] query_node;
        logic [NODE_W-1:0] reached_count;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLR_ADJ,
        ST_IDLE,
        ST_EDGE_B,
        ST_Q_START,
        ST_DEQ,
        ST_DEQ_WAIT,
        ST_ROW_RD,
        ST_ROW_LOAD,
        ST_ROW_SCAN,
        ST_ROW_END,
        ST_CLR_VIS,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic edge_a;
        logic edge_b;
        logic q_start;
        logic load_cur;
        logic load_cand;
        logic enqueue;
        logic next_chunk;
        logic row_end;
        logic clr_vis_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic op_query;
        logic edge_ok;
        logic query_ok;
        logic cand_empty;
        logic chunk_last;
        logic chunk_all;
        logic level_break;
        logic queue_empty;
        logic out_free;
    } status_t;

    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> hw/rtl/dlbfs_ctrl.sv
// Sequencer for the BFS reach counter: reset sweep, edge writes, search loop.
// Drives datapath commands from its status; depends on dlbfs_pkg.
module dlbfs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dlbfs_pkg::status_t status,
    output dlbfs_pkg::cmd_t    cmd
);
    import dlbfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR_ADJ;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLR_ADJ: begin
                cmd.clr_step = 1'b1;
                if (status.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.op_query) begin
                        if (status.query_ok) begin
                            state_next = ST_Q_START;
                        end
                    end else if (status.edge_ok) begin
                        cmd.edge_a = 1'b1;
                        state_next = ST_EDGE_B;
                    end
                end
            end
            ST_EDGE_B: begin
                cmd.edge_b = 1'b1;
                state_next = ST_IDLE;
            end
            ST_Q_START: begin
                cmd.q_start = 1'b1;
                state_next  = ST_DEQ;
            end
            ST_DEQ: begin
                state_next = ST_DEQ_WAIT;
            end
            ST_DEQ_WAIT: begin
                cmd.load_cur = 1'b1;
                state_next   = ST_ROW_RD;
            end
            ST_ROW_RD: begin
                state_next = ST_ROW_LOAD;
            end
            ST_ROW_LOAD: begin
                cmd.load_cand = 1'b1;
                state_next    = ST_ROW_SCAN;
            end
            ST_ROW_SCAN: begin
                if (!status.cand_empty) begin
                    cmd.enqueue = 1'b1;
                end else if (status.chunk_last) begin
                    state_next = ST_ROW_END;
                end else begin
                    cmd.next_chunk = 1'b1;
                    state_next     = ST_ROW_RD;
                end
            end
            ST_ROW_END: begin
                cmd.row_end = 1'b1;
                if (status.level_break || status.queue_empty) begin
                    state_next = ST_CLR_VIS;
                end else begin
                    state_next = ST_DEQ;
                end
            end
            ST_CLR_VIS: begin
                cmd.clr_vis_step = 1'b1;
                if (status.chunk_all) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLR_ADJ;
            end
        endcase
    end

endmodule

>>> hw/rtl/dlbfs_datapath.sv
// Datapath of the BFS reach counter: adjacency, visited and queue memories,
// search counters, configuration registers and the result register.
// Depends on dlbfs_pkg; sequenced by dlbfs_ctrl.
module dlbfs_datapath #(
    parameter int MAX_NODES = dlbfs_pkg::MAX_NODES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  dlbfs_pkg::cmd_t                      cmd,
    output dlbfs_pkg::status_t                   status,
    input  dlbfs_pkg::in_item_t                  s_item,
    input  logic                                 cfg_valid,
    input  logic [dlbfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dlbfs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output dlbfs_pkg::out_item_t                 m_item
);
    import dlbfs_pkg::*;

    localparam int NW        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW        = $clog2(MAX_NODES + 1);
    localparam int WPR       = (MAX_NODES + WORD_W - 1) / WORD_W;
    localparam int CHW       = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int CHUNKS    = 1 << CHW;
    localparam int COLW      = CHW + BIT_W;
    localparam int AW        = NW + CHW;
    localparam int ADJ_DEPTH = MAX_NODES * CHUNKS;
    localparam int CMPW      = (CW > NODE_W) ? CW : NODE_W;
    localparam int LVW       = (CW > DEPTH_W) ? CW : DEPTH_W;
    localparam int MW        = (COLW > CW) ? COLW : CW;

    localparam logic [WORD_W-1:0] BIT0 = WORD_W'(1);

    logic [WORD_W-1:0] adj_mem [ADJ_DEPTH];
    logic [WORD_W-1:0] vis_mem [CHUNKS];
    logic [NW-1:0]     q_mem   [MAX_NODES];

    logic [NODE_W-1:0]  node_count_reg;
    logic [DEPTH_W-1:0] depth_limit_reg;
    in_item_t           item_reg;
    logic [AW-1:0]      clr_reg;
    logic [NW-1:0]      cur_reg;
    logic [CHW-1:0]     chunk_reg;
    logic [CW-1:0]      head_reg;
    logic [CW-1:0]      tail_reg;
    logic [CW-1:0]      reached_reg;
    logic [LVW-1:0]     level_reg;
    logic [NW-1:0]      last_reg;
    logic [NW-1:0]      ltail_reg;
    logic [WORD_W-1:0]  cand_reg;
    logic [WORD_W-1:0]  adj_rd_reg;
    logic [WORD_W-1:0]  vis_rd_reg;
    logic [NW-1:0]      q_rd_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic [CMPW-1:0]   nc_ext;
    logic [CW-1:0]     n_eff;
    logic [COLW-1:0]   last_col;
    logic [COLW-1:0]   col_a_in;
    logic [COLW-1:0]   col_b_in;
    logic [COLW-1:0]   col_a_reg;
    logic [COLW-1:0]   col_b_reg;
    logic [COLW-1:0]   col_s_reg;
    logic [NW-1:0]     s_idx;
    logic [BIT_W-1:0]  lsb;
    logic [COLW-1:0]   j_col;
    logic [NW-1:0]     j_idx;
    logic [WORD_W-1:0] range_mask;
    logic              level_end;
    logic [LVW-1:0]    level_inc;

    logic              adj_we;
    logic [AW-1:0]     adj_waddr;
    logic [WORD_W-1:0] adj_wmask;
    logic [WORD_W-1:0] adj_wdata;
    logic              vis_we;
    logic [CHW-1:0]    vis_waddr;
    logic [WORD_W-1:0] vis_wmask;
    logic [WORD_W-1:0] vis_wdata;
    logic              q_we;
    logic [NW-1:0]     q_waddr;
    logic [NW-1:0]     q_wdata;

    function automatic logic in_range(input logic [NODE_W-1:0] x, input logic [CW-1:0] n);
        return (x != '0) && (CMPW'(x) <= CMPW'(n));
    endfunction

    function automatic logic [COLW-1:0] to_col(input logic [NODE_W-1:0] x);
        logic [NODE_W-1:0] xm;
        xm = x - NODE_W'(1);
        return COLW'(NW'(xm));
    endfunction

    assign nc_ext = CMPW'(node_count_reg);
    assign n_eff  = (nc_ext > CMPW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(nc_ext);

    assign last_col  = COLW'(NW'(n_eff - CW'(1)));
    assign col_a_in  = to_col(s_item.edge_node_a);
    assign col_b_in  = to_col(s_item.edge_node_b);
    assign col_a_reg = to_col(item_reg.edge_node_a);
    assign col_b_reg = to_col(item_reg.edge_node_b);
    assign col_s_reg = to_col(item_reg.start_node);
    assign s_idx     = NW'(col_s_reg);

    assign lsb   = lowest_set(cand_reg);
    assign j_col = {chunk_reg, lsb};
    assign j_idx = NW'(j_col);

    always_comb begin
        logic [COLW-1:0] col;
        for (int i = 0; i < WORD_W; i++) begin
            col           = {chunk_reg, BIT_W'(i)};
            range_mask[i] = MW'(col) < MW'(n_eff);
        end
    end

    assign level_end = (cur_reg == last_reg);
    assign level_inc = level_reg + LVW'(1);

    always_comb begin
        status             = '0;
        status.clr_done    = (clr_reg == AW'(ADJ_DEPTH - 1));
        status.op_query    = (s_item.op == OP_QUERY);
        status.edge_ok     = in_range(s_item.edge_node_a, n_eff) &&
                             in_range(s_item.edge_node_b, n_eff);
        status.query_ok    = in_range(s_item.start_node, n_eff);
        status.cand_empty  = (cand_reg == '0);
        status.chunk_last  = (chunk_reg == last_col[COLW-1:BIT_W]);
        status.chunk_all   = &chunk_reg;
        status.level_break = level_end && (level_inc == LVW'(depth_limit_reg));
        status.queue_empty = (head_reg == tail_reg);
        status.out_free    = !out_valid_reg || m_ready;
    end

    always_comb begin
        adj_we    = 1'b0;
        adj_waddr = clr_reg;
        adj_wmask = '1;
        adj_wdata = '0;
        if (cmd.clr_step) begin
            adj_we = 1'b1;
        end else if (cmd.edge_a) begin
            adj_we    = 1'b1;
            adj_waddr = {NW'(col_a_in), col_b_in[COLW-1:BIT_W]};
            adj_wmask = BIT0 << col_b_in[BIT_W-1:0];
            adj_wdata = '1;
        end else if (cmd.edge_b) begin
            adj_we    = 1'b1;
            adj_waddr = {NW'(col_b_reg), col_a_reg[COLW-1:BIT_W]};
            adj_wmask = BIT0 << col_a_reg[BIT_W-1:0];
            adj_wdata = '1;
        end
    end

    always_comb begin
        vis_we    = 1'b0;
        vis_waddr = chunk_reg;
        vis_wmask = '1;
        vis_wdata = '0;
        if (cmd.clr_step) begin
            vis_we    = 1'b1;
            vis_waddr = clr_reg[CHW-1:0];
        end else if (cmd.clr_vis_step) begin
            vis_we = 1'b1;
        end else if (cmd.q_start) begin
            vis_we    = 1'b1;
            vis_waddr = col_s_reg[COLW-1:BIT_W];
            vis_wmask = BIT0 << col_s_reg[BIT_W-1:0];
            vis_wdata = '1;
        end else if (cmd.enqueue) begin
            vis_we    = 1'b1;
            vis_wmask = BIT0 << lsb;
            vis_wdata = '1;
        end
    end

    always_comb begin
        q_we    = cmd.q_start || cmd.enqueue;
        q_waddr = cmd.q_start ? '0 : tail_reg[NW-1:0];
        q_wdata = cmd.q_start ? s_idx : j_idx;
    end

    always_ff @(posedge aclk) begin
        if (adj_we) begin
            for (int i = 0; i < WORD_W; i++) begin
                if (adj_wmask[i]) begin
                    adj_mem[adj_waddr][i] <= adj_wdata[i];
                end
            end
        end
        adj_rd_reg <= adj_mem[{cur_reg, chunk_reg}];
    end

    always_ff @(posedge aclk) begin
        if (vis_we) begin
            for (int i = 0; i < WORD_W; i++) begin
                if (vis_wmask[i]) begin
                    vis_mem[vis_waddr][i] <= vis_wdata[i];
                end
            end
        end
        vis_rd_reg <= vis_mem[chunk_reg];
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rd_reg <= q_mem[head_reg[NW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg  <= NODE_COUNT_RST;
            depth_limit_reg <= DEPTH_LIMIT_RST;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_NODE_COUNT:  node_count_reg  <= NODE_W'(cfg_data);
                    CFG_DEPTH_LIMIT: depth_limit_reg <= DEPTH_W'(cfg_data);
                    default: ;
                endcase
            end
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_item;
        end
        if (cmd.q_start) begin
            head_reg    <= '0;
            tail_reg    <= CW'(1);
            reached_reg <= CW'(1);
            level_reg   <= '0;
            last_reg    <= s_idx;
            ltail_reg   <= s_idx;
        end
        if (cmd.load_cur) begin
            cur_reg   <= q_rd_reg;
            chunk_reg <= '0;
            head_reg  <= head_reg + CW'(1);
        end
        if (cmd.load_cand) begin
            cand_reg <= adj_rd_reg & ~vis_rd_reg & range_mask;
        end
        if (cmd.enqueue) begin
            cand_reg    <= cand_reg & (cand_reg - WORD_W'(1));
            tail_reg    <= tail_reg + CW'(1);
            reached_reg <= reached_reg + CW'(1);
            ltail_reg   <= j_idx;
        end
        if (cmd.next_chunk || cmd.clr_vis_step) begin
            chunk_reg <= chunk_reg + CHW'(1);
        end
        if (cmd.row_end) begin
            chunk_reg <= '0;
            if (level_end) begin
                level_reg <= level_inc;
                last_reg  <= ltail_reg;
            end
        end
        if (cmd.load_out) begin
            out_reg.query_node    <= item_reg.start_node;
            out_reg.reached_count <= NODE_W'(reached_reg);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

>>> hw/rtl/depth_limited_bfs_reach_count_unit.sv
// Top level of the depth-limited BFS reach counter.
// Joins dlbfs_ctrl and dlbfs_datapath; depends on dlbfs_pkg.
//
// Input channel s_valid/s_ready/s_item carries two kinds of item. An edge item
// (op 0) marks nodes edge_node_a and edge_node_b adjacent; it writes the
// adjacency store in the cycle it is taken and in the next, with s_ready low
// for the second write. A query item (op 1) runs a breadth-first search from
// start_node and returns one item on m_valid/m_ready/m_item with the number of
// nodes within depth_limit hops, start included (all reachable nodes when
// depth_limit is 0). Items with an endpoint or start node outside 1..node_count
// (node_count capped at MAX_NODES) are dropped without a result. A query holds
// s_ready low until its result is loaded into the output register. The search
// dequeues each node, reads its C = ceil(n/32) 32-bit row words one at a
// time, with n the active node count, and enqueues one node per cycle. Then
// K = 2^ceil(log2(ceil(MAX_NODES/32))) visited words (32 at 1024 nodes) are
// cleared. The cfg_valid/cfg_ready/cfg_index/cfg_data port writes node_count
// (index 0) and depth_limit (index 1). After reset the adjacency store's
// MAX_NODES * K words (32768 at 1024 nodes) and the visited store are swept to
// zero with s_ready low. A result waits in the output register while m_ready is
// low; a finished query then holds until the register is free.
module depth_limited_bfs_reach_count_unit #(
    parameter int MAX_NODES = dlbfs_pkg::MAX_NODES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  dlbfs_pkg::in_item_t              s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output dlbfs_pkg::out_item_t             m_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dlbfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dlbfs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dlbfs_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    dlbfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dlbfs_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_item    (s_item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_item    (m_item)
    );

endmodule

>>> dv/depth_limited_bfs_reach_count_unit_tb.sv
// Self-checking testbench for depth_limited_bfs_reach_count_unit: edge loads, reach-count
// queries and register writes under random idling, checked against an in-bench graph model.
// Depends on dlbfs_pkg and the unit under test only.
module depth_limited_bfs_reach_count_unit_tb;
    import dlbfs_pkg::*;

    localparam int MAXN          = MAX_NODES_DEF;
    localparam int PAIR_TOTAL    = MAXN * (MAXN + 1) / 2;
    localparam int SETTLE_CYCLES = 2 * MAXN + 64;
    localparam int HOLD_CYCLES   = 3000;
    localparam int QUIET_LIMIT   = 400000;
    localparam int PLAN_LEN      = 31;

    typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        int                    reg_val;
        op_t                   op;
        int                    a;
        int                    b;
        int                    s;
        int                    want;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit                    pair_bit [0:PAIR_TOTAL-1];
    logic [NODE_W-1:0]     node_cfg  = NODE_COUNT_RST;
    logic [DEPTH_W-1:0]    depth_cfg = DEPTH_LIMIT_RST;
    out_item_t             pending_answers [$];
    out_item_t             head_answer;
    int                    mismatches    = 0;
    int                    quiet_cycles  = 0;
    int                    send_idle_pct = 0;
    int                    stall_pct     = 0;
    bit                    hold_req      = 1'b0;

    plan_row_t plan [0:PLAN_LEN-1] = '{
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    1,    1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    1024, 1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    1025, -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  0,    5,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  2047, 2047, 0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  1024, 1,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    1,    2},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  3,    3,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    3,    1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  1,    2,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  2,    3,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  3,    4,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  4,    5,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  5,    6,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  6,    7,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  7,    8,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    1,    -1},
        '{ROW_REG,  CFG_DEPTH_LIMIT, 1,    OP_EDGE,  0,    0,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    1,    -1},
        '{ROW_REG,  CFG_DEPTH_LIMIT, 0,    OP_EDGE,  0,    0,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    8,    -1},
        '{ROW_REG,  CFG_DEPTH_LIMIT, 63,   OP_EDGE,  0,    0,    0,    -1},
        '{ROW_REG,  CFG_NODE_COUNT,  4,    OP_EDGE,  0,    0,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    4,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    5,    -1},
        '{ROW_REG,  CFG_NODE_COUNT,  0,    OP_EDGE,  0,    0,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    1,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_EDGE,  1,    1,    0,    -1},
        '{ROW_REG,  CFG_NODE_COUNT,  2047, OP_EDGE,  0,    0,    0,    -1},
        '{ROW_ITEM, CFG_NODE_COUNT,  0,    OP_QUERY, 0,    0,    1024, -1}
    };

    depth_limited_bfs_reach_count_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic int unsigned live_nodes();
        return (node_cfg > MAXN) ? MAXN : node_cfg;
    endfunction

    function automatic int unsigned pair_slot(input int unsigned x, input int unsigned y);
        int unsigned hi;
        int unsigned lo;
        hi = ((x > y) ? x : y) - 1;
        lo = ((x > y) ? y : x) - 1;
        return hi * (hi + 1) / 2 + lo;
    endfunction

    function automatic int unsigned count_reach(input int unsigned start, input int unsigned n);
        bit          seen [0:MAXN];
        int unsigned order [0:MAXN-1];
        int unsigned head;
        int unsigned tail;
        int unsigned cnt;
        int unsigned cur;
        int unsigned lvl;
        int unsigned lvl_last;
        int unsigned lvl_tail;
        foreach (seen[k]) seen[k] = 1'b0;
        head     = 0;
        tail     = 0;
        cnt      = 1;
        lvl      = 0;
        lvl_last = start;
        lvl_tail = start;
        seen[start] = 1'b1;
        order[tail] = start;
        tail++;
        while (head < tail) begin
            cur = order[head];
            head++;
            for (int unsigned j = 1; j <= n; j++) begin
                if (!seen[j] && pair_bit[pair_slot(j, cur)] && tail < MAXN) begin
                    seen[j]     = 1'b1;
                    order[tail] = j;
                    tail++;
                    cnt++;
                    lvl_tail = j;
                end
            end
            if (cur == lvl_last) begin
                lvl++;
                lvl_last = lvl_tail;
            end
            if (lvl == depth_cfg) break;
        end
        return cnt;
    endfunction

    function automatic bit graph_step(input in_item_t it, output out_item_t res);
        int unsigned n;
        int unsigned a;
        int unsigned b;
        int unsigned s;
        n   = live_nodes();
        a   = it.edge_node_a;
        b   = it.edge_node_b;
        s   = it.start_node;
        res = '0;
        if (it.op == OP_EDGE) begin
            if (a >= 1 && a <= n && b >= 1 && b <= n) pair_bit[pair_slot(a, b)] = 1'b1;
            return 1'b0;
        end
        if (s < 1 || s > n) return 1'b0;
        res.query_node    = it.start_node;
        res.reached_count = NODE_W'(count_reach(s, n));
        return 1'b1;
    endfunction

    function automatic int unsigned pick_node(input int unsigned n);
        if ($urandom_range(1, 0) != 0) return $urandom_range(n, 1);
        return $urandom_range((n < 64) ? n : 64, 1);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int exp_val);
        if (mismatches < 100) begin
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
        end
        mismatches++;
    endtask

    task automatic send_item(input in_item_t it, input int want);
        out_item_t res;
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99, 0) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (graph_step(it, res)) begin
            if (want >= 0) res.reached_count = NODE_W'(want);
            pending_answers.push_back(res);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NODE_COUNT:  node_cfg  = NODE_W'(val);
            CFG_DEPTH_LIMIT: depth_cfg = DEPTH_W'(val);
            default: ;
        endcase
    endtask

    task automatic run_phase(input int nodes, input int depth, input int idle_pct,
                             input int stall, input int items, input int query_pct,
                             input bit hold);
        in_item_t    it;
        int unsigned n;
        int unsigned a;
        write_reg(CFG_DEPTH_LIMIT, depth);
        write_reg(CFG_NODE_COUNT, nodes);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        hold_req      = hold;
        n             = live_nodes();
        repeat (items) begin
            it.edge_node_a = NODE_W'($urandom);
            it.edge_node_b = NODE_W'($urandom);
            it.start_node  = NODE_W'($urandom);
            if ($urandom_range(99, 0) < query_pct) begin
                it.op = OP_QUERY;
                if (n != 0 && $urandom_range(9, 0) != 0) it.start_node = NODE_W'(pick_node(n));
            end else begin
                it.op = OP_EDGE;
                if (n != 0 && $urandom_range(9, 0) != 0) begin
                    a = pick_node(n);
                    it.edge_node_a = NODE_W'(a);
                    if ($urandom_range(1, 0) != 0) begin
                        it.edge_node_b = NODE_W'(pick_node(n));
                    end else begin
                        it.edge_node_b = NODE_W'((a + $urandom_range(3, 0)) % n + 1);
                    end
                end
            end
            send_item(it, -1);
        end
    endtask

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                flag_mismatch("unexpected result, query_node", m_item.query_node, 0);
            end else begin
                head_answer = pending_answers.pop_front();
                if (m_item.query_node !== head_answer.query_node) begin
                    flag_mismatch("query_node", m_item.query_node, head_answer.query_node);
                end
                if (m_item.reached_count !== head_answer.reached_count) begin
                    flag_mismatch("reached_count", m_item.reached_count,
                                  head_answer.reached_count);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        in_item_t probe;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_NODE_COUNT;
        cfg_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                probe.op          = plan[i].op;
                probe.edge_node_a = (plan[i].op == OP_EDGE) ? NODE_W'(plan[i].a) : NODE_W'($urandom);
                probe.edge_node_b = (plan[i].op == OP_EDGE) ? NODE_W'(plan[i].b) : NODE_W'($urandom);
                probe.start_node  = (plan[i].op == OP_QUERY) ? NODE_W'(plan[i].s) : NODE_W'($urandom);
                send_item(probe, plan[i].want);
            end
        end

        run_phase(16,   2,  0,  0,  100, 40, 1'b0);
        run_phase(64,   6,  71, 0,  80,  40, 1'b0);
        run_phase(1,    1,  0,  71, 20,  50, 1'b0);
        run_phase(2047, 3,  9,  9,  60,  25, 1'b0);
        run_phase(40,   0,  0,  0,  100, 60, 1'b1);
        run_phase(8,    63, 0,  71, 60,  50, 1'b0);
        run_phase(300,  4,  71, 0,  60,  25, 1'b0);
        run_phase(0,    5,  0,  0,  15,  50, 1'b0);
        run_phase(1024, 1,  0,  71, 60,  40, 1'b0);

        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
